/* hw/rtl/cioc_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// cioc_pkg: shared types and constants of the console I/O port controller
// Register offsets, configuration indexes, device codes and reset table.
// ---------------------------------------------------------------------------
package cioc_pkg;

  localparam int unsigned PortCount = 3;

  // register offsets
  localparam logic [3:0] OffVersion = 4'd0;
  localparam logic [3:0] OffDataA   = 4'd1;
  localparam logic [3:0] OffDataB   = 4'd2;
  localparam logic [3:0] OffDataC   = 4'd3;
  localparam logic [3:0] OffCtrlA   = 4'd4;
  localparam logic [3:0] OffCtrlB   = 4'd5;
  localparam logic [3:0] OffCtrlC   = 4'd6;
  localparam logic [3:0] OffTxA     = 4'd7;
  localparam logic [3:0] OffSerA    = 4'd9;
  localparam logic [3:0] OffTxB     = 4'd10;
  localparam logic [3:0] OffSerB    = 4'd12;
  localparam logic [3:0] OffTxC     = 4'd13;
  localparam logic [3:0] OffSerC    = 4'd15;

  // configuration register indexes
  localparam logic [2:0] CfgRegionFirst  = 3'd0;
  localparam logic [2:0] CfgRegionSecond = 3'd1;
  localparam logic [2:0] CfgRegionThird  = 3'd2;
  localparam logic [2:0] CfgRegionOrder  = 3'd3;
  localparam logic [2:0] CfgDevA         = 3'd4;
  localparam logic [2:0] CfgDevB         = 3'd5;
  localparam logic [2:0] CfgDevC         = 3'd6;

  typedef enum logic [1:0] {
    DevNone  = 2'd0,
    DevTwo   = 2'd1,
    DevThree = 2'd2,
    DevSix   = 2'd3
  } dev_e;

  typedef enum logic [1:0] {
    OrdUsaEurJap = 2'd0,
    OrdEurUsaJap = 2'd1,
    OrdJapUsaEur = 2'd2,
    OrdSpare     = 2'd3
  } ord_e;

  localparam logic       OpRead  = 1'b0;
  localparam logic       OpWrite = 1'b1;

  localparam logic [7:0] CodeJapan  = 8'h00;
  localparam logic [7:0] CodeUsa    = 8'h80;
  localparam logic [7:0] CodeEurope = 8'hC0;
  localparam logic [7:0] NoDiscBit  = 8'h20;
  localparam logic [7:0] SerMask    = 8'hF8;

  typedef logic [7:0] byte_t;

  function automatic byte_t bank_reset(input logic [3:0] idx);
    byte_t v;
    v = 8'h00;
    case (idx)
      OffVersion:                 v = 8'hA0;
      OffDataA, OffDataB, OffDataC: v = 8'h7F;
      OffTxA, OffTxB:             v = 8'hFF;
      OffTxC:                     v = 8'hFB;
      default:                    v = 8'h00;
    endcase
    return v;
  endfunction

  // region character class: 2'b01 Japan, 2'b10 Europe, 2'b00 USA
  function automatic logic [1:0] region_class(input byte_t ch);
    logic [1:0] c;
    c = 2'b00;
    if (ch == 8'h4A) c = 2'b01;
    else if (ch == 8'h45 || ch == 8'h41 || ch == 8'h42 || ch == 8'h34) c = 2'b10;
    return c;
  endfunction

  // active-low directions, B and C in bits 0..5
  function automatic byte_t pad_full(input byte_t b);
    return {2'b00, ~b[6], ~b[5], ~b[3], ~b[2], ~b[1], ~b[0]};
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/console_io_port_controller.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// console_io_port_controller: three-port console I/O register block
// Byte reads and writes at 16 register offsets with pad sampling and a
// version byte derived from the cartridge header region.
// ---------------------------------------------------------------------------
// Channel    Direction  Handshake             Payload
// s_axis     in         tvalid/tready         tuser: op; tdata: offset, wdata, buttons a/b/c
// m_axis     out        tvalid/tready         tdata: rdata
// cfg        in         cfg_we_i              cfg_idx_i, cfg_data_i
//
// One item per cycle while m_axis takes each result: the access is decoded and
// the register bank updated at the accepting edge, and the read byte lands in the output register.
// The output register is the only stage; a new item is taken whenever it is
// empty or being drained, so a stalled m_axis holds s_axis off until the
// waiting result is taken.
// Reset loads the register bank with its default table, clears select
// latches, configuration and the output valid flag.
// ---------------------------------------------------------------------------
module console_io_port_controller #(
  parameter int unsigned PORT_COUNT = cioc_pkg::PortCount
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic        s_axis_tuser,   // [0] op
  // [3:0] offset, [11:4] wdata, [19:12] buttons_a, [27:20] buttons_b,
  // [35:28] buttons_c, [39:36] zero
  input  wire logic [39:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] rdata
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i
);

  // ---- configuration registers ----
  cioc_pkg::byte_t region_q [3];
  cioc_pkg::ord_e  order_q;
  cioc_pkg::dev_e  dev_q    [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q[0] <= '0;
      region_q[1] <= '0;
      region_q[2] <= '0;
      order_q     <= cioc_pkg::OrdUsaEurJap;
      dev_q[0]    <= cioc_pkg::DevNone;
      dev_q[1]    <= cioc_pkg::DevNone;
      dev_q[2]    <= cioc_pkg::DevNone;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cioc_pkg::CfgRegionFirst:  region_q[0] <= cfg_data_i;
        cioc_pkg::CfgRegionSecond: region_q[1] <= cfg_data_i;
        cioc_pkg::CfgRegionThird:  region_q[2] <= cfg_data_i;
        cioc_pkg::CfgRegionOrder:  order_q     <= cioc_pkg::ord_e'(cfg_data_i[1:0]);
        cioc_pkg::CfgDevA:         dev_q[0]    <= cioc_pkg::dev_e'(cfg_data_i[1:0]);
        cioc_pkg::CfgDevB:         dev_q[1]    <= cioc_pkg::dev_e'(cfg_data_i[1:0]);
        cioc_pkg::CfgDevC:         dev_q[2]    <= cioc_pkg::dev_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // ---- input item fields ----
  logic       in_op;
  logic [3:0] in_off;
  logic [7:0] in_wdata;
  logic [7:0] in_btn [3];
  logic       in_acc;

  assign in_op     = s_axis_tuser;
  assign in_off    = s_axis_tdata[3:0];
  assign in_wdata  = s_axis_tdata[11:4];
  assign in_btn[0] = s_axis_tdata[19:12];
  assign in_btn[1] = s_axis_tdata[27:20];
  assign in_btn[2] = s_axis_tdata[35:28];

  // ---- state ----
  cioc_pkg::byte_t        bank_q [16];
  cioc_pkg::byte_t        bank_d [16];
  logic [PORT_COUNT-1:0]  select_q, select_d;
  logic                   out_valid_q;
  cioc_pkg::byte_t        out_data_q, out_data_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---- version byte: best-priority region among the three characters ----
  logic            has_jap, has_eur, has_usa;
  cioc_pkg::byte_t version;

  always_comb begin
    has_jap = 1'b0;
    has_eur = 1'b0;
    has_usa = 1'b0;
    for (int i = 0; i < 3; i++) begin
      case (cioc_pkg::region_class(region_q[i]))
        2'b01:   has_jap = 1'b1;
        2'b10:   has_eur = 1'b1;
        default: has_usa = 1'b1;
      endcase
    end
    case (order_q)
      cioc_pkg::OrdEurUsaJap:
        version = has_eur ? cioc_pkg::CodeEurope :
                  has_usa ? cioc_pkg::CodeUsa : cioc_pkg::CodeJapan;
      cioc_pkg::OrdJapUsaEur:
        version = has_jap ? cioc_pkg::CodeJapan :
                  has_usa ? cioc_pkg::CodeUsa : cioc_pkg::CodeEurope;
      default: // USA-first order, and the spare order falls back to it
        version = has_usa ? cioc_pkg::CodeUsa :
                  has_eur ? cioc_pkg::CodeEurope : cioc_pkg::CodeJapan;
    endcase
    version = version | cioc_pkg::NoDiscBit;
  end

  // ---- per-port view of the addressed data register ----
  logic [1:0]      port;
  cioc_pkg::byte_t port_ctrl, port_btn, port_data, wr_masked;
  cioc_pkg::dev_e  port_dev;
  logic            port_sel;

  always_comb begin
    port = in_off[1:0] - 2'd1;
    case (port)
      2'd0:    begin port_ctrl = bank_q[4]; port_btn = in_btn[0]; port_data = bank_q[1]; end
      2'd1:    begin port_ctrl = bank_q[5]; port_btn = in_btn[1]; port_data = bank_q[2]; end
      default: begin port_ctrl = bank_q[6]; port_btn = in_btn[2]; port_data = bank_q[3]; end
    endcase
    // ports past PORT_COUNT read as unplugged
    port_dev = cioc_pkg::DevNone;
    if (int'(port) < int'(PORT_COUNT)) begin
      case (port)
        2'd0:    port_dev = dev_q[0];
        2'd1:    port_dev = dev_q[1];
        default: port_dev = dev_q[2];
      endcase
    end
    port_sel = 1'b0;
    for (int i = 0; i < int'(PORT_COUNT); i++) begin
      if (port == 2'(i)) port_sel = select_q[i];
    end
    wr_masked = (in_wdata & 8'h80) | (in_wdata & port_ctrl);
  end

  // ---- access decode: bank update and read byte ----
  always_comb begin
    bank_d     = bank_q;
    select_d   = select_q;
    out_data_d = '0;
    if (in_op == cioc_pkg::OpWrite) begin
      case (in_off) inside
        cioc_pkg::OffDataA, cioc_pkg::OffDataB, cioc_pkg::OffDataC: begin
          bank_d[in_off] = wr_masked;
          if (port_dev == cioc_pkg::DevThree) begin
            for (int i = 0; i < int'(PORT_COUNT); i++) begin
              if (port == 2'(i)) select_d[i] = wr_masked[6];
            end
          end
        end
        cioc_pkg::OffCtrlA, cioc_pkg::OffCtrlB, cioc_pkg::OffCtrlC,
        cioc_pkg::OffTxA, cioc_pkg::OffTxB, cioc_pkg::OffTxC:
          bank_d[in_off] = in_wdata;
        cioc_pkg::OffSerA, cioc_pkg::OffSerB, cioc_pkg::OffSerC:
          bank_d[in_off] = in_wdata & cioc_pkg::SerMask;
        default: ; // version and reserved offsets ignore writes
      endcase
    end else begin
      case (in_off) inside
        cioc_pkg::OffVersion: out_data_d = version;
        cioc_pkg::OffDataA, cioc_pkg::OffDataB, cioc_pkg::OffDataC: begin
          case (port_dev)
            cioc_pkg::DevTwo:
              out_data_d = (port_data & 8'h80) | cioc_pkg::pad_full(port_btn);
            cioc_pkg::DevThree:
              if (port_sel) begin
                out_data_d = (port_data & 8'h80) | cioc_pkg::pad_full(port_btn) | 8'h40;
              end else begin
                out_data_d = (port_data & 8'h80) |
                             {2'b00, ~port_btn[7], ~port_btn[4], 2'b00,
                              ~port_btn[1], ~port_btn[0]};
              end
            default: // unplugged or six-button: inputs float high
              out_data_d = port_data | (~port_ctrl & 8'h7F);
          endcase
        end
        default: out_data_d = bank_q[in_off];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) bank_q[i] <= cioc_pkg::bank_reset(4'(i));
      select_q <= '0;
    end else if (in_acc) begin
      bank_q   <= bank_d;
      select_q <= select_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) out_data_q <= out_data_d;
  end

  // ---- assertions ----
  a_write_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_op == cioc_pkg::OpWrite) |=> (m_axis_tvalid && m_axis_tdata == 8'h00))
    else $error("write item did not return a zero byte");

  a_version_no_disc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_op == cioc_pkg::OpRead && in_off == cioc_pkg::OffVersion)
      |=> m_axis_tdata[5])
    else $error("version byte lost the no-disc flag");

  a_select_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(select_q) |-> $past(in_acc && in_op == cioc_pkg::OpWrite))
    else $error("select latch moved without a data write");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty output register");

endmodule
`default_nettype wire

/* verif/tb_console_io_port_controller.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_console_io_port_controller: self-checking bench for the console I/O block
// Streams byte accesses with random pad states into the block, predicts each
// read byte from a local copy of the register bank, select latches and
// configuration, and checks every returned item in order. Both handshakes
// idle at random; one phase holds the output off long enough to back up the
// input. The run steps through several configurations, extremes among them.
// ---------------------------------------------------------------------------
module tb_console_io_port_controller;

  // offsets with no register behind them; writes there are dropped
  localparam logic [3:0] OffSpare8  = 4'd8;
  localparam logic [3:0] OffSpare11 = 4'd11;
  localparam logic [3:0] OffSpare14 = 4'd14;

  localparam int PhaseCount    = 8;
  localparam int ItemsPerPhase = 68;
  localparam int LongHoldCycles = 80;

  // one access as the sender sees it
  typedef struct packed {
    logic            op;
    logic [3:0]      offset;
    cioc_pkg::byte_t wdata;
    cioc_pkg::byte_t btn_c;
    cioc_pkg::byte_t btn_b;
    cioc_pkg::byte_t btn_a;
  } port_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic        s_axis_tuser = 1'b0;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [7:0]  cfg_data_i = '0;

  console_io_port_controller DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),   // [0] op
    // [3:0] offset, [11:4] wdata, [19:12] buttons_a, [27:20] buttons_b,
    // [35:28] buttons_c, [39:36] zero
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] rdata
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // -------------------------------------------------------------------------
  // Local copy of the block state, advanced once per accepted item
  // -------------------------------------------------------------------------
  cioc_pkg::byte_t bank_m [16];
  logic            sel_m  [3];
  cioc_pkg::byte_t hdr_m  [3];
  cioc_pkg::ord_e  ord_m;
  cioc_pkg::dev_e  dev_m  [3];

  port_item_t      pending       [$];   // accesses waiting for the driver
  cioc_pkg::byte_t rdata_expected[$];   // read bytes still owed by the block
  cioc_pkg::byte_t cfg_plan      [7];   // next configuration, by register index

  port_item_t on_bus;
  int         send_gap = 0;
  int         recv_hold = 0;
  int         long_hold_reqs = 0;
  int         long_hold_done = 0;
  bit         quiet = 1'b0;        // last phase: no idling on either side
  int         err_count = 0;

  function automatic cioc_pkg::byte_t region_code_of(input cioc_pkg::byte_t ch);
    cioc_pkg::byte_t c;
    c = cioc_pkg::CodeUsa;
    if (ch == "J") c = cioc_pkg::CodeJapan;
    else if (ch == "E" || ch == "A" || ch == "B" || ch == "4") c = cioc_pkg::CodeEurope;
    return c;
  endfunction

  // best-ranked region among the three header characters, plus no-disc flag
  function automatic cioc_pkg::byte_t version_of();
    cioc_pkg::byte_t rank [3];
    cioc_pkg::byte_t code;
    int              best;
    best = 2;
    case (ord_m)
      cioc_pkg::OrdEurUsaJap: begin
        rank[0] = cioc_pkg::CodeEurope; rank[1] = cioc_pkg::CodeUsa;
        rank[2] = cioc_pkg::CodeJapan;
      end
      cioc_pkg::OrdJapUsaEur: begin
        rank[0] = cioc_pkg::CodeJapan; rank[1] = cioc_pkg::CodeUsa;
        rank[2] = cioc_pkg::CodeEurope;
      end
      default: begin  // spare order falls back to USA first
        rank[0] = cioc_pkg::CodeUsa; rank[1] = cioc_pkg::CodeEurope;
        rank[2] = cioc_pkg::CodeJapan;
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      code = region_code_of(hdr_m[i]);
      for (int k = 0; k < 3; k++) begin
        if (rank[k] == code && k < best) best = k;
      end
    end
    return rank[best] | cioc_pkg::NoDiscBit;
  endfunction

  // two-button pad (also three-button with select high): active low
  function automatic cioc_pkg::byte_t pad_two_of(input cioc_pkg::byte_t b);
    return {2'b00, ~b[6], ~b[5], ~b[3], ~b[2], ~b[1], ~b[0]};
  endfunction

  // three-button pad with select low: up, down, A, start
  function automatic cioc_pkg::byte_t pad_three_low_of(input cioc_pkg::byte_t b);
    return {2'b00, ~b[7], ~b[4], 2'b00, ~b[1], ~b[0]};
  endfunction

  // applies one access to the local state and returns the byte read back
  function automatic cioc_pkg::byte_t apply_access(input port_item_t it);
    cioc_pkg::byte_t r;
    cioc_pkg::byte_t v;
    cioc_pkg::byte_t btn;
    int              p;
    cioc_pkg::dev_e  dev;
    r = 8'h00;
    p = int'(it.offset) - 1;
    if (it.op == cioc_pkg::OpWrite) begin
      case (it.offset)
        cioc_pkg::OffDataA, cioc_pkg::OffDataB, cioc_pkg::OffDataC: begin
          // bit 7 always kept, others only where the control marks outputs
          v = (it.wdata & 8'h80) | (it.wdata & bank_m[it.offset + 3]);
          bank_m[it.offset] = v;
          if (p < cioc_pkg::PortCount && dev_m[p] == cioc_pkg::DevThree) sel_m[p] = v[6];
        end
        cioc_pkg::OffCtrlA, cioc_pkg::OffCtrlB, cioc_pkg::OffCtrlC,
        cioc_pkg::OffTxA, cioc_pkg::OffTxB, cioc_pkg::OffTxC:
          bank_m[it.offset] = it.wdata;
        cioc_pkg::OffSerA, cioc_pkg::OffSerB, cioc_pkg::OffSerC:
          bank_m[it.offset] = it.wdata & cioc_pkg::SerMask;
        default: ;  // version and spare offsets ignore writes
      endcase
    end else begin
      case (it.offset)
        cioc_pkg::OffVersion: r = version_of();
        cioc_pkg::OffDataA, cioc_pkg::OffDataB, cioc_pkg::OffDataC: begin
          dev = (p < cioc_pkg::PortCount) ? dev_m[p] : cioc_pkg::DevNone;
          btn = (p == 0) ? it.btn_a : (p == 1) ? it.btn_b : it.btn_c;
          if (dev == cioc_pkg::DevTwo)
            r = (bank_m[it.offset] & 8'h80) | pad_two_of(btn);
          else if (dev == cioc_pkg::DevThree)
            r = (bank_m[it.offset] & 8'h80) |
                (sel_m[p] ? (pad_two_of(btn) | 8'h40) : pad_three_low_of(btn));
          else  // no pad or six-button: input bits float high
            r = bank_m[it.offset] | (~bank_m[it.offset + 3] & 8'h7F);
        end
        default: r = bank_m[it.offset];
      endcase
    end
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Driver: offers queued accesses, records expectations on acceptance
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        rdata_expected.push_back(apply_access(on_bus));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          on_bus = pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= on_bus.op;
          s_axis_tdata  <= {4'b0000, on_bus.btn_c, on_bus.btn_b, on_bus.btn_a,
                            on_bus.wdata, on_bus.offset};
          // idle burst after this item
          if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 14);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: checks each returned byte in order, stalls the output at random
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (rdata_expected.size() == 0) begin
          $error("unexpected item: rdata %02h with nothing outstanding", m_axis_tdata);
          err_count++;
        end else begin
          if (m_axis_tdata !== rdata_expected[0]) begin
            $error("rdata mismatch: expected %02h, actual %02h",
                   rdata_expected[0], m_axis_tdata);
            err_count++;
          end
          void'(rdata_expected.pop_front());
        end
      end
      // a long hold lets the output register fill and block the input
      if (long_hold_done != long_hold_reqs) begin
        long_hold_done++;
        recv_hold = LongHoldCycles;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_hold = $urandom_range(0, 13);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  function automatic port_item_t make_access(input logic op, input logic [3:0] off,
                                             input cioc_pkg::byte_t wd);
    port_item_t it;
    it.op     = op;
    it.offset = off;
    it.wdata  = wd;
    it.btn_a  = cioc_pkg::byte_t'($urandom);
    it.btn_b  = cioc_pkg::byte_t'($urandom);
    it.btn_c  = cioc_pkg::byte_t'($urandom);
    return it;
  endfunction

  function automatic cioc_pkg::byte_t pick_region_char();
    cioc_pkg::byte_t ch;
    case ($urandom_range(0, 6))
      0: ch = "J";
      1: ch = "U";
      2: ch = "E";
      3: ch = "A";
      4: ch = "B";
      5: ch = "4";
      default: ch = cioc_pkg::byte_t'($urandom);
    endcase
    return ch;
  endfunction

  // mostly pad sessions (direction setup, select toggling, reads), rest noise
  task automatic queue_random(input int count);
    int made;
    int p;
    int k;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 1) == 0) begin
        p = $urandom_range(0, 2);
        pending.push_back(make_access(cioc_pkg::OpWrite, cioc_pkg::OffCtrlA + 4'(p),
                          ($urandom_range(0, 3) == 0) ? cioc_pkg::byte_t'($urandom) : 8'h40));
        k = $urandom_range(2, 6);
        repeat (k) begin
          pending.push_back(make_access(cioc_pkg::OpWrite, cioc_pkg::OffDataA + 4'(p),
                                        cioc_pkg::byte_t'($urandom)));
          pending.push_back(make_access(cioc_pkg::OpRead, cioc_pkg::OffDataA + 4'(p),
                                        cioc_pkg::byte_t'($urandom)));
        end
        made += 1 + 2 * k;
      end else begin
        pending.push_back(make_access(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                                      cioc_pkg::byte_t'($urandom)));
        made++;
      end
    end
  endtask

  // block quiet: nothing queued, nothing offered, nothing owed; sampled at the
  // falling edge so the driver's updates of the last rising edge are settled
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending.size() != 0 || s_axis_tvalid || rdata_expected.size() != 0 ||
           m_axis_tvalid);
  endtask

  // writes every register from cfg_plan, one per edge, then mirrors it
  task automatic program_config();
    for (int i = 0; i < 7; i++) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 3'(i);
      cfg_data_i <= cfg_plan[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hdr_m[0] = cfg_plan[cioc_pkg::CfgRegionFirst];
    hdr_m[1] = cfg_plan[cioc_pkg::CfgRegionSecond];
    hdr_m[2] = cfg_plan[cioc_pkg::CfgRegionThird];
    ord_m    = cioc_pkg::ord_e'(cfg_plan[cioc_pkg::CfgRegionOrder][1:0]);
    dev_m[0] = cioc_pkg::dev_e'(cfg_plan[cioc_pkg::CfgDevA][1:0]);
    dev_m[1] = cioc_pkg::dev_e'(cfg_plan[cioc_pkg::CfgDevB][1:0]);
    dev_m[2] = cioc_pkg::dev_e'(cfg_plan[cioc_pkg::CfgDevC][1:0]);
  endtask

  // -------------------------------------------------------------------------
  // Sequence: reset, directed accesses, configuration phases, drain
  // -------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < 16; i++) bank_m[i] = cioc_pkg::bank_reset(4'(i));
    for (int i = 0; i < 3; i++) begin
      sel_m[i] = 1'b0;
      hdr_m[i] = 8'h00;
      dev_m[i] = cioc_pkg::DevNone;
    end
    ord_m = cioc_pkg::OrdUsaEurJap;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset table on every offset
    for (int i = 0; i < 16; i++) begin
      pending.push_back(make_access(cioc_pkg::OpRead, 4'(i), 8'h00));
    end
    // writes to the version byte and spare offsets must leave them alone
    pending.push_back(make_access(cioc_pkg::OpWrite, cioc_pkg::OffVersion, 8'hFF));
    pending.push_back(make_access(cioc_pkg::OpWrite, OffSpare8, 8'hFF));
    pending.push_back(make_access(cioc_pkg::OpWrite, OffSpare11, 8'hFF));
    pending.push_back(make_access(cioc_pkg::OpWrite, OffSpare14, 8'hFF));
    pending.push_back(make_access(cioc_pkg::OpRead, cioc_pkg::OffVersion, 8'h00));
    pending.push_back(make_access(cioc_pkg::OpRead, OffSpare11, 8'h00));
    // data write masked by an all-input control; serial control drops low bits
    pending.push_back(make_access(cioc_pkg::OpWrite, cioc_pkg::OffDataA, 8'hFF));
    pending.push_back(make_access(cioc_pkg::OpWrite, cioc_pkg::OffSerA, 8'hFF));
    pending.push_back(make_access(cioc_pkg::OpRead, cioc_pkg::OffDataA, 8'h00));
    pending.push_back(make_access(cioc_pkg::OpRead, cioc_pkg::OffSerA, 8'h00));

    for (int ph = 0; ph < PhaseCount; ph++) begin
      wait_idle();
      // headers: all zero, all ones, then region letters mixed with noise
      for (int i = 0; i < 3; i++) begin
        cfg_plan[i] = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : pick_region_char();
      end
      // early phases walk every order and every device code on each port
      if (ph < 4) begin
        cfg_plan[cioc_pkg::CfgRegionOrder] = cioc_pkg::byte_t'(ph);
        cfg_plan[cioc_pkg::CfgDevA]        = cioc_pkg::byte_t'(ph % 4);
        cfg_plan[cioc_pkg::CfgDevB]        = cioc_pkg::byte_t'((ph + 1) % 4);
        cfg_plan[cioc_pkg::CfgDevC]        = cioc_pkg::byte_t'((ph + 2) % 4);
      end else begin
        cfg_plan[cioc_pkg::CfgRegionOrder] = cioc_pkg::byte_t'($urandom_range(0, 3));
        cfg_plan[cioc_pkg::CfgDevA]        = cioc_pkg::byte_t'($urandom_range(0, 3));
        cfg_plan[cioc_pkg::CfgDevB]        = cioc_pkg::byte_t'($urandom_range(0, 3));
        cfg_plan[cioc_pkg::CfgDevC]        = cioc_pkg::byte_t'($urandom_range(0, 3));
      end
      program_config();
      if (ph == 3) long_hold_reqs++;
      if (ph == PhaseCount - 1) quiet = 1'b1;
      queue_random(ItemsPerPhase);
    end

    wait_idle();
    repeat (5) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/cioc_pkg.sv
hw/rtl/console_io_port_controller.sv
verif/tb_console_io_port_controller.sv
